// ===== hdl/fda_pkg.sv =====
// fda_pkg: shared constants, widths and queue entry type for the
// fixed-point to decimal ascii formatter; no dependencies
package fda_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int INT_BITS        = 32;
  localparam int VALUE_W         = 48;
  localparam int CHAR_W          = 7;
  localparam int FD_W            = 4;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int DIGIT_IDX_W     = $clog2(BCD_DIGITS);
  localparam int BIT_CNT_W       = (INT_BITS > 1) ? $clog2(INT_BITS) : 1;

  // queue depth must be a power of two
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_IDX_W       = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_DIGITS = '0;
  localparam logic [FD_W-1:0]      FD_RESET            = FD_W'(1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;

  // one converted value waiting to be printed
  typedef struct packed {
    logic [BCD_W-1:0]       bcd;
    logic [DIGIT_IDX_W-1:0] top;
    logic [FRAC_BITS-1:0]   frac;
    logic [FD_W-1:0]        k;
  } fda_entry_t;

endpackage

// ===== hdl/fda_ifs.sv =====
// fda_ifs: valid/ready stream interfaces for the input values and the
// output characters; depends on fda_pkg
interface fda_in_if;
  logic                          valid;
  logic                          ready;
  logic [fda_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fda_out_if;
  logic                          valid;
  logic                          ready;
  logic [fda_pkg::CHAR_W-1:0]    character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hdl/fda_front.sv =====
// fda_front: takes values in, converts the integer part to bcd by
// shift-and-add-3 and pushes one entry per value; depends on fda_pkg, fda_ifs
module fda_front (
  input  logic                     clk,
  input  logic                     rst_n,
  fda_in_if.sink                   in_ch,
  input  logic [fda_pkg::FD_W-1:0] k_sat,
  input  logic                     q_full,
  output logic                     q_push,
  output fda_pkg::fda_entry_t      q_entry
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fda_fstate_t;

  fda_fstate_t                         state_r, state_nxt;
  logic [fda_pkg::INT_BITS-1:0]        bin_r, bin_nxt;
  logic [fda_pkg::BCD_W-1:0]           bcd_r, bcd_nxt, bcd_adj;
  logic [fda_pkg::FRAC_BITS-1:0]       frac_r, frac_nxt;
  logic [fda_pkg::FD_W-1:0]            k_r, k_nxt;
  logic [fda_pkg::BIT_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [fda_pkg::DIGIT_IDX_W-1:0]     top;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < fda_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // highest nonzero digit, zero when the integer part is zero
  always_comb begin
    top = '0;
    for (int i = 1; i < fda_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        top = fda_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign in_ch.ready   = (state_r == F_IDLE);
  assign q_push        = (state_r == F_PUSH) && !q_full;
  assign q_entry.bcd   = bcd_r;
  assign q_entry.top   = top;
  assign q_entry.frac  = frac_r;
  assign q_entry.k     = k_r;

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    frac_nxt  = frac_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          bin_nxt   = in_ch.value[fda_pkg::FRAC_BITS +: fda_pkg::INT_BITS];
          frac_nxt  = in_ch.value[fda_pkg::FRAC_BITS-1:0];
          bcd_nxt   = '0;
          k_nxt     = k_sat;
          cnt_nxt   = fda_pkg::BIT_CNT_W'(fda_pkg::INT_BITS - 1);
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_nxt = {bcd_adj[fda_pkg::BCD_W-2:0], bin_r[fda_pkg::INT_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// ===== hdl/fda_queue.sv =====
// fda_queue: small register fifo between the converter and the printer;
// depends on fda_pkg
module fda_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fda_pkg::fda_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output fda_pkg::fda_entry_t head,
  output logic                empty
);

  fda_pkg::fda_entry_t            mem_r [fda_pkg::QUEUE_DEPTH];
  logic [fda_pkg::QPTR_W-1:0]     wptr_r, wptr_nxt;
  logic [fda_pkg::QPTR_W-1:0]     rptr_r, rptr_nxt;
  logic [fda_pkg::QPTR_W:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (fda_pkg::QPTR_W+1)'(fda_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/fda_back.sv =====
// fda_back: prints one queued entry as ascii, one character per transfer,
// with a registered output stage; depends on fda_pkg, fda_ifs
module fda_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fda_pkg::fda_entry_t q_head,
  output logic                q_pop,
  fda_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_INT  = 4'b0010,
    B_DOT  = 4'b0100,
    B_FRAC = 4'b1000
  } fda_bstate_t;

  localparam int PROD_W = fda_pkg::FRAC_BITS + 4;

  fda_bstate_t                       state_r, state_nxt;
  logic [fda_pkg::BCD_W-1:0]         bcd_r, bcd_nxt;
  logic [fda_pkg::DIGIT_IDX_W-1:0]   idx_r, idx_nxt;
  logic [fda_pkg::FRAC_BITS-1:0]     frac_r, frac_nxt;
  logic [fda_pkg::FD_W-1:0]          k_r, k_nxt;
  logic [fda_pkg::FD_W-1:0]          cnt_r, cnt_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic [fda_pkg::CHAR_W-1:0]        char_r, char_nxt;
  logic                              last_r, last_nxt;
  logic                              adv;
  logic [PROD_W-1:0]                 prod;
  logic [3:0]                        int_digit;

  // next fraction digit: frac * 10, integer part falls out on top
  assign prod      = ({4'b0, frac_r} << 3) + ({4'b0, frac_r} << 1);
  assign int_digit = bcd_r[4*idx_r +: 4];
  assign adv       = !ovalid_r || out_ch.ready;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  assign out_ch.valid     = ovalid_r;
  assign out_ch.character = char_r;
  assign out_ch.last      = last_r;

  always_comb begin
    state_nxt  = state_r;
    bcd_nxt    = bcd_r;
    idx_nxt    = idx_r;
    frac_nxt   = frac_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = adv ? 1'b0 : ovalid_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          bcd_nxt   = q_head.bcd;
          idx_nxt   = q_head.top;
          frac_nxt  = q_head.frac;
          k_nxt     = q_head.k;
          state_nxt = B_INT;
        end
      end
      B_INT: begin
        if (adv) begin
          ovalid_nxt = 1'b1;
          char_nxt   = fda_pkg::ASCII_ZERO + {3'b000, int_digit};
          last_nxt   = (k_r == '0) && (idx_r == '0);
          idx_nxt    = idx_r - 1'b1;
          if (idx_r == '0) begin
            state_nxt = (k_r == '0) ? B_IDLE : B_DOT;
          end
        end
      end
      B_DOT: begin
        if (adv) begin
          ovalid_nxt = 1'b1;
          char_nxt   = fda_pkg::ASCII_POINT;
          last_nxt   = 1'b0;
          cnt_nxt    = k_r;
          state_nxt  = B_FRAC;
        end
      end
      B_FRAC: begin
        if (adv) begin
          ovalid_nxt = 1'b1;
          char_nxt   = fda_pkg::ASCII_ZERO + {3'b000, prod[PROD_W-1 -: 4]};
          last_nxt   = (cnt_r == fda_pkg::FD_W'(1));
          frac_nxt   = prod[fda_pkg::FRAC_BITS-1:0];
          cnt_nxt    = cnt_r - 1'b1;
          if (cnt_r == fda_pkg::FD_W'(1)) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    bcd_r  <= bcd_nxt;
    idx_r  <= idx_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== hdl/fixed_to_decimal_ascii.sv =====
// fixed_to_decimal_ascii: from input transfer to first character, a value passes
// through load, 32 shift-and-add-3 steps, queue push, printer load and output register
// the converter takes a new value only after it has pushed the last one; the printer
// loads an entry, then gives one character per cycle while out_ch is ready
// reset (rst_n low, synchronous) empties the queue and output stage and sets
// fraction_digits to 1
module fixed_to_decimal_ascii (
  input  logic                              clk,
  input  logic                              rst_n,
  fda_in_if.sink                            in_ch,
  fda_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fda_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [fda_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [fda_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [fda_pkg::FD_W-1:0]      fd_r, fd_nxt;
  logic [fda_pkg::FD_W-1:0]      k_sat;
  logic                          reg_hit;
  logic                          cfg_wr;
  logic                          q_push, q_pop, q_full, q_empty;
  fda_pkg::fda_entry_t           q_in, q_head;

  // configuration: one register at word 0, writes complete in the access phase
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[fda_pkg::CFG_ADDR_W-1:2] == fda_pkg::REG_FRACTION_DIGITS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && reg_hit;
  assign fd_nxt     = cfg_wr ? cfg_pwdata[fda_pkg::FD_W-1:0] : fd_r;
  assign cfg_prdata = reg_hit ? {{(fda_pkg::CFG_DATA_W-fda_pkg::FD_W){1'b0}}, fd_r} : '0;

  // more than nine fraction digits clamps to nine
  assign k_sat = (fd_r > fda_pkg::FD_W'(fda_pkg::MAX_FRAC_DIGITS))
                 ? fda_pkg::FD_W'(fda_pkg::MAX_FRAC_DIGITS) : fd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r <= fda_pkg::FD_RESET;
    end else begin
      fd_r <= fd_nxt;
    end
  end

  // front: input transfer and binary to bcd conversion
  fda_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .k_sat   (k_sat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // queue lets the converter start the next value while text is printed
  fda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // back: integer digits, then, unless k is zero, point and fraction digits by repeated times ten
  fda_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
